/* hw/rtl/tcw_pkg.sv */
// Package for the text console writer: screen geometry, cell codes and
// the packed beat types of the input and result channels.
// Depends on nothing; used by text_console_writer.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int CELL_AW = $clog2(CELLS);

    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [7:0]  RESET_COLOR  = 8'h07;
    localparam logic [15:0] RESET_CELL   = {RESET_COLOR, SPACE_CODE};

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_position;
        logic [15:0] cell_value;
    } out_item_t;

endpackage

/* hw/rtl/tcw_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/text_console_writer.sv */
// Text console writer top level: sequencer, cursor registers and result register.
// Depends on tcw_pkg and tcw_ram.
//
// Usage: input beats carry a command (put character, clear line, read cell).
// Every accepted beat yields exactly one result beat with the cursor after
// the command and, for a read, the addressed cell. The color register is
// written through cfg_wen/cfg_wdata and colors every character and cleared
// cell written later. A single screen RAM port pair serves all work: an
// ordinary character, an unused command or a read past the screen goes from
// EXEC straight to DONE, a newline or row wrap without scroll passes NEWROW,
// a read passes READ, and a line clear fills its row's COLUMNS cells in FILL.
// A newline or row wrap on the last row scrolls: one cell is copied per
// cycle, then the bottom row is filled.
// The block takes one item at a time; in_ready is high only when idle, from
// the cycle after the result is loaded.
// After reset all CELLS (2000) cells of the RAM are swept to spaces in light
// grey, one cell a cycle, with in_ready low; configuration writes still land.
// A result waits in the output register while out_ready is low; the next
// item is taken and worked on meanwhile and holds in its last step until
// the register frees.
module text_console_writer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tcw_pkg::in_item_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output tcw_pkg::out_item_t out_data,
    input  logic             cfg_wen,
    input  logic [7:0]       cfg_wdata
);

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_EXEC   = 4'd2;
    localparam logic [3:0] ST_NEWROW = 4'd3;
    localparam logic [3:0] ST_SCROLL = 4'd4;
    localparam logic [3:0] ST_FILL   = 4'd5;
    localparam logic [3:0] ST_READ   = 4'd6;
    localparam logic [3:0] ST_DONE   = 4'd7;

    localparam int AW = tcw_pkg::CELL_AW;
    localparam logic [AW-1:0] CELLS_A    = AW'(tcw_pkg::CELLS);
    localparam logic [AW-1:0] COLUMNS_A  = AW'(tcw_pkg::COLUMNS);
    localparam logic [AW-1:0] LAST_BASE  = AW'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS);
    localparam logic [6:0]    LAST_COL   = 7'(tcw_pkg::COLUMNS - 1);
    localparam logic [4:0]    LAST_ROW   = 5'(tcw_pkg::ROWS - 1);

    logic [3:0]          state_reg, state_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [6:0]          col_reg, col_next;
    logic [4:0]          row_reg, row_next;
    logic [AW-1:0]       base_reg, base_next;
    logic [7:0]          color_reg;
    tcw_pkg::in_item_t   item_reg;
    logic [15:0]         cell_reg, cell_next;
    logic                out_valid_reg;
    tcw_pkg::out_item_t  out_reg;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [15:0]         ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [15:0]         ram_rdata;
    logic [AW-1:0]       cursor_addr;
    logic                in_fire;
    logic                out_load;

    tcw_ram #(
        .WIDTH(16),
        .DEPTH(tcw_pkg::CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign out_data    = out_reg;
    assign cursor_addr = base_reg + AW'(col_reg);
    assign out_load    = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        base_next  = base_reg;
        cell_next  = cell_reg;
        ram_we     = 1'b0;
        ram_waddr  = addr_reg;
        ram_wdata  = {color_reg, tcw_pkg::SPACE_CODE};
        ram_raddr  = '0;
        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = tcw_pkg::RESET_CELL;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == CELLS_A - 1'b1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cell_next = '0;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (item_reg.cmd)
                    tcw_pkg::CMD_PUT:
                    begin
                        if (item_reg.char_code == tcw_pkg::NEWLINE_CODE)
                        begin
                            col_next   = '0;
                            state_next = ST_NEWROW;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cursor_addr;
                            ram_wdata = {color_reg, item_reg.char_code};
                            if (col_reg == LAST_COL)
                            begin
                                col_next   = '0;
                                state_next = ST_NEWROW;
                            end
                            else
                            begin
                                col_next   = col_reg + 1'b1;
                                state_next = ST_DONE;
                            end
                        end
                    end
                    tcw_pkg::CMD_CLEAR:
                    begin
                        col_next   = '0;
                        addr_next  = base_reg;
                        state_next = ST_FILL;
                    end
                    tcw_pkg::CMD_READ:
                    begin
                        if (item_reg.cell_index < CELLS_A)
                        begin
                            ram_raddr  = item_reg.cell_index;
                            state_next = ST_READ;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_NEWROW:
            begin
                if (row_reg == LAST_ROW)
                begin
                    addr_next  = COLUMNS_A;
                    state_next = ST_SCROLL;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    base_next  = base_reg + COLUMNS_A;
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL:
            begin
                // Each read is issued in the cycle before the write it feeds, which lands one row up.
                if (addr_reg != CELLS_A)
                begin
                    ram_raddr = addr_reg;
                end
                if (addr_reg > COLUMNS_A)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = addr_reg - COLUMNS_A - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (addr_reg == CELLS_A)
                begin
                    addr_next  = LAST_BASE;
                    state_next = ST_FILL;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == base_reg + AW'(LAST_COL))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                cell_next  = ram_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            addr_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            base_reg      <= '0;
            color_reg     <= tcw_pkg::RESET_COLOR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            base_reg  <= base_next;
            if (cfg_wen)
            begin
                color_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
        if (in_fire)
        begin
            item_reg <= in_data;
        end
        if (out_load)
        begin
            out_reg.cursor_column   <= col_reg;
            out_reg.cursor_row      <= row_reg;
            out_reg.cursor_position <= cursor_addr;
            out_reg.cell_value      <= cell_reg;
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input taken again while an item is in progress");

    a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= LAST_COL) && (row_reg <= LAST_ROW))
        else $error("cursor outside the screen");

    a_row_base: assert property (@(posedge clk) disable iff (!rst_n)
        32'(base_reg) == 32'(row_reg) * 32'(tcw_pkg::COLUMNS))
        else $error("row base out of step with cursor row");

    a_scroll_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL) && ram_we |-> (ram_waddr < addr_reg))
        else $error("scroll write overtook its read");

    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid && in_ready)
        else $error("result not presented after completion");

endmodule
